[sv/bds_pkg.sv]
`default_nettype none

package bds_pkg;

    localparam int unsigned BAUD_W       = 24;
    localparam int unsigned REF_W        = 32;
    localparam int unsigned CLK_DIV_W    = 16;
    localparam int unsigned SMP_DIV_W    = 8;
    localparam int unsigned SMP_CNT_W    = SMP_DIV_W + 1;
    localparam int unsigned DIVISOR_W    = BAUD_W + SMP_CNT_W;
    localparam int unsigned BIT_CNT_W    = $clog2(REF_W);

    localparam int unsigned SAMPLE_DIV_FIRST_DEF = 4;
    localparam int unsigned SAMPLE_DIV_LIMIT_DEF = 255;
    localparam int unsigned CLOCK_DIV_MAX_DEF    = 65535;

    localparam logic [CLK_DIV_W-1:0] CLOCK_DIV_MIN     = CLK_DIV_W'(2);
    localparam logic [CLK_DIV_W-1:0] DEFAULT_CLOCK_DIV = CLK_DIV_W'(2);
    localparam logic [SMP_DIV_W-1:0] DEFAULT_SMP_DIV   = SMP_DIV_W'(4);
    localparam logic [REF_W-1:0]     REF_CLOCK_RESET   = REF_W'(50000000);

endpackage

`default_nettype wire

[sv/baud_divisor_search_unit.sv]
// Baud divisor search unit.
// Input channel (s_valid/s_ready, s_baud_rate): one requested baud rate per transfer.
// Result channel (m_valid/m_ready, m_clock_divider, m_sample_divider): one divider
// pair per input transfer, the candidate with the smallest rate error, earliest on ties,
// or 2 and 4 when none fits.
// Configuration: cfg_wr_en with cfg_wr_data writes the reference clock in hertz;
// write only while the unit is idle.
// Every sample divider from SAMPLE_DIV_FIRST to SAMPLE_DIV_LIMIT-1 is tried on one
// shared restoring divider (one quotient bit per cycle).
// A candidate whose clock divider is out of range skips the second division; a kept
// one runs it and has its rate error checked. A zero baud rate skips the search.
// s_ready is low for the whole search.
// The result register is separate from the search: a stalled receiver only holds
// the unit at the end of a following search until the old result is taken.
// Reset (aresetn, synchronous) empties the result register, returns the
// sequencer to idle and restores the reference clock to 50000000.
`default_nettype none

module baud_divisor_search_unit #(
    parameter int unsigned SAMPLE_DIV_FIRST = bds_pkg::SAMPLE_DIV_FIRST_DEF,
    parameter int unsigned SAMPLE_DIV_LIMIT = bds_pkg::SAMPLE_DIV_LIMIT_DEF,
    parameter int unsigned CLOCK_DIV_MAX    = bds_pkg::CLOCK_DIV_MAX_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bds_pkg::REF_W-1:0]       cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [bds_pkg::BAUD_W-1:0]      s_baud_rate,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bds_pkg::CLK_DIV_W-1:0]        m_clock_divider,
    output logic [bds_pkg::SMP_DIV_W-1:0]        m_sample_divider
);

    localparam int unsigned REF_W  = bds_pkg::REF_W;
    localparam int unsigned BAUD_W = bds_pkg::BAUD_W;
    localparam int unsigned CNT_W  = bds_pkg::SMP_CNT_W;
    localparam int unsigned DVS_W  = bds_pkg::DIVISOR_W;
    localparam int unsigned BIT_W  = bds_pkg::BIT_CNT_W;
    localparam int unsigned CLK_W  = bds_pkg::CLK_DIV_W;
    localparam int unsigned SMP_W  = bds_pkg::SMP_DIV_W;
    localparam int unsigned GMUL_W = CLK_W + CNT_W;

    localparam logic [CNT_W-1:0] S_FIRST = CNT_W'(SAMPLE_DIV_FIRST);
    localparam logic [CNT_W-1:0] S_LAST  = CNT_W'(SAMPLE_DIV_LIMIT - 1);
    localparam logic [REF_W-1:0] G_MAX   = REF_W'(CLOCK_DIV_MAX);
    localparam logic [REF_W-1:0] G_MIN   = REF_W'(bds_pkg::CLOCK_DIV_MIN);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPAN  = 3'd1;
    localparam logic [2:0] ST_DIVG  = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_DIVR  = 3'd4;
    localparam logic [2:0] ST_EVAL  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [REF_W-1:0]  ref_clk_reg;
    logic [BAUD_W-1:0] baud_reg, baud_next;
    logic [CNT_W-1:0]  smp_reg, smp_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [REF_W-1:0]  quo_reg, quo_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [CLK_W-1:0]  g_reg, g_next;
    logic [REF_W-1:0]  best_err_reg, best_err_next;
    logic [CLK_W-1:0]  best_g_reg, best_g_next;
    logic [SMP_W-1:0]  best_s_reg, best_s_next;
    logic              m_valid_reg, m_valid_next;
    logic [CLK_W-1:0]  m_clk_reg, m_clk_next;
    logic [SMP_W-1:0]  m_smp_reg, m_smp_next;

    logic [DVS_W:0]    trial;
    logic              trial_ge;
    logic [DVS_W:0]    trial_sub;
    logic [CNT_W-1:0]  smp_plus1;
    logic [REF_W-1:0]  err;
    logic              out_free;

    assign smp_plus1 = smp_reg + CNT_W'(1);
    assign trial     = {rem_reg, quo_reg[REF_W-1]};
    assign trial_ge  = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign err       = (quo_reg > REF_W'(baud_reg)) ? (quo_reg - REF_W'(baud_reg))
                                                    : (REF_W'(baud_reg) - quo_reg);
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_clock_divider  = m_clk_reg;
    assign m_sample_divider = m_smp_reg;

    always_comb begin
        state_next    = state_reg;
        baud_next     = baud_reg;
        smp_next      = smp_reg;
        dvs_next      = dvs_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        bit_next      = bit_reg;
        g_next        = g_reg;
        best_err_next = best_err_reg;
        best_g_next   = best_g_reg;
        best_s_next   = best_s_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_clk_next    = m_clk_reg;
        m_smp_next    = m_smp_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    baud_next     = s_baud_rate;
                    smp_next      = S_FIRST;
                    best_err_next = REF_W'(s_baud_rate);
                    best_g_next   = bds_pkg::DEFAULT_CLOCK_DIV;
                    best_s_next   = bds_pkg::DEFAULT_SMP_DIV;
                    state_next    = (s_baud_rate == '0) ? ST_DONE : ST_SPAN;
                end
            end
            ST_SPAN: begin
                dvs_next   = DVS_W'(baud_reg) * DVS_W'(smp_plus1);
                rem_next   = '0;
                quo_next   = ref_clk_reg;
                bit_next   = '1;
                state_next = ST_DIVG;
            end
            ST_DIVG, ST_DIVR: begin
                rem_next = trial_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
                quo_next = {quo_reg[REF_W-2:0], trial_ge};
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0) begin
                    state_next = (state_reg == ST_DIVG) ? ST_CHECK : ST_EVAL;
                end
            end
            ST_CHECK: begin
                if (quo_reg >= G_MIN && quo_reg <= G_MAX) begin
                    g_next     = quo_reg[CLK_W-1:0];
                    dvs_next   = DVS_W'(GMUL_W'(quo_reg[CLK_W-1:0]) * GMUL_W'(smp_plus1));
                    rem_next   = '0;
                    quo_next   = ref_clk_reg;
                    bit_next   = '1;
                    state_next = ST_DIVR;
                end else begin
                    smp_next   = smp_plus1;
                    state_next = (smp_reg == S_LAST) ? ST_DONE : ST_SPAN;
                end
            end
            ST_EVAL: begin
                if (err < best_err_reg) begin
                    best_err_next = err;
                    best_g_next   = g_reg;
                    best_s_next   = smp_reg[SMP_W-1:0];
                end
                smp_next   = smp_plus1;
                state_next = (smp_reg == S_LAST) ? ST_DONE : ST_SPAN;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_clk_next   = best_g_reg;
                    m_smp_next   = best_s_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            ref_clk_reg <= bds_pkg::REF_CLOCK_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                ref_clk_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        baud_reg     <= baud_next;
        smp_reg      <= smp_next;
        dvs_reg      <= dvs_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        bit_reg      <= bit_next;
        g_reg        <= g_next;
        best_err_reg <= best_err_next;
        best_g_reg   <= best_g_next;
        best_s_reg   <= best_s_next;
        m_clk_reg    <= m_clk_next;
        m_smp_reg    <= m_smp_next;
    end

    // divisor is never zero while a division runs
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVG || state_reg == ST_DIVR) |-> (dvs_reg != '0))
        else $error("zero divisor in shared divider");

    // a transfer in always takes the unit out of idle
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start a search");

    // delivered clock divider stays in its legal range
    a_clk_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (REF_W'(m_clock_divider) >= G_MIN && REF_W'(m_clock_divider) <= G_MAX))
        else $error("clock divider out of range");

    // best error never grows during a search
    a_err_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |=> (best_err_reg <= $past(best_err_reg)))
        else $error("best error increased");

endmodule

`default_nettype wire

[tb/tb_baud_divisor_search_unit.sv]
`default_nettype none

module tb_baud_divisor_search_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BAUD_W               = bds_pkg::BAUD_W;
    localparam int unsigned REF_W                = bds_pkg::REF_W;
    localparam int unsigned CLK_DIV_W            = bds_pkg::CLK_DIV_W;
    localparam int unsigned SMP_DIV_W            = bds_pkg::SMP_DIV_W;
    localparam int unsigned SAMPLE_DIV_FIRST_DEF = bds_pkg::SAMPLE_DIV_FIRST_DEF;
    localparam int unsigned SAMPLE_DIV_LIMIT_DEF = bds_pkg::SAMPLE_DIV_LIMIT_DEF;
    localparam int unsigned CLOCK_DIV_MAX_DEF    = bds_pkg::CLOCK_DIV_MAX_DEF;
    localparam logic [CLK_DIV_W-1:0] CLOCK_DIV_MIN     = bds_pkg::CLOCK_DIV_MIN;
    localparam logic [CLK_DIV_W-1:0] DEFAULT_CLOCK_DIV = bds_pkg::DEFAULT_CLOCK_DIV;
    localparam logic [SMP_DIV_W-1:0] DEFAULT_SMP_DIV   = bds_pkg::DEFAULT_SMP_DIV;
    localparam logic [REF_W-1:0]     REF_CLOCK_RESET   = bds_pkg::REF_CLOCK_RESET;

    localparam longint unsigned CYCLE_LIMIT = 64'd12_000_000;
    localparam logic [BAUD_W-1:0] BAUD_ALL_ONES = '1;
    localparam logic [REF_W-1:0] REF_ALL_ONES = '1;

    typedef struct {
        logic [BAUD_W-1:0]    baud;
        logic [CLK_DIV_W-1:0] clock_divider;
        logic [SMP_DIV_W-1:0] sample_divider;
    } divider_choice_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [REF_W-1:0]      cfg_wr_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BAUD_W-1:0]     s_baud_rate = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CLK_DIV_W-1:0]  m_clock_divider;
    logic [SMP_DIV_W-1:0]  m_sample_divider;

    logic [REF_W-1:0]      ref_clock_now = REF_CLOCK_RESET;
    divider_choice_t       pending_choices[$];
    int unsigned           mismatch_count = 0;
    longint unsigned       cycle_count = 0;
    int unsigned           stall_left = 0;
    bit                    quiet = 1'b0;

    baud_divisor_search_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_baud_rate      (s_baud_rate),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_clock_divider  (m_clock_divider),
        .m_sample_divider (m_sample_divider)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // exhaustive search over sample dividers, earliest pair kept on equal error
    function automatic divider_choice_t best_divider_pair(input logic [REF_W-1:0] ref_hz,
                                                          input logic [BAUD_W-1:0] baud);
        divider_choice_t best;
        longint unsigned ref_l;
        longint unsigned baud_l;
        longint unsigned best_err;
        longint unsigned g;
        longint unsigned got;
        longint unsigned err;
        int unsigned     s;
        ref_l = ref_hz;
        baud_l = baud;
        best.baud = baud;
        best.clock_divider = DEFAULT_CLOCK_DIV;
        best.sample_divider = DEFAULT_SMP_DIV;
        best_err = baud_l;
        if (baud_l != 0) begin
            for (s = SAMPLE_DIV_FIRST_DEF; s < SAMPLE_DIV_LIMIT_DEF; s++) begin
                g = ref_l / (baud_l * (s + 1));
                if (g < CLOCK_DIV_MIN || g > CLOCK_DIV_MAX_DEF) continue;
                got = ref_l / (g * (s + 1));
                err = (got > baud_l) ? got - baud_l : baud_l - got;
                if (err < best_err) begin
                    best_err = err;
                    best.clock_divider = CLK_DIV_W'(g);
                    best.sample_divider = SMP_DIV_W'(s);
                end
            end
        end
        return best;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        int unsigned r;
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 30) begin
            r = $urandom_range(0, 99);
            stall_left = (r < 90) ? $urandom_range(1, 5) : $urandom_range(50, 300);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checking
    always @(posedge aclk) begin
        divider_choice_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_choices.size() == 0) begin
                mismatch_count++;
                $display("%0t: result transfer with nothing outstanding, actual %0d / %0d",
                         $time, m_clock_divider, m_sample_divider);
            end else begin
                want = pending_choices.pop_front();
                if (m_clock_divider !== want.clock_divider) begin
                    mismatch_count++;
                    $display("%0t: clock_divider for baud %0d: expected %0d, actual %0d",
                             $time, want.baud, want.clock_divider, m_clock_divider);
                end
                if (m_sample_divider !== want.sample_divider) begin
                    mismatch_count++;
                    $display("%0t: sample_divider for baud %0d: expected %0d, actual %0d",
                             $time, want.baud, want.sample_divider, m_sample_divider);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_choices.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid is left high after a transfer so a back-to-back item needs no re-raise
    task automatic send_baud(input logic [BAUD_W-1:0] baud);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_baud_rate <= baud;
        do @(posedge aclk); while (!s_ready);
        pending_choices.push_back(best_divider_pair(ref_clock_now, baud));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_choices.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_ref_clock(input logic [REF_W-1:0] hz);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= hz;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ref_clock_now = hz;
    endtask

    task automatic test_reset_clock();
        quiet = 1'b0;
        send_baud(24'd115200);
        send_baud(24'd9600);
        send_baud('0);
        send_baud(24'd1);
        send_baud(24'd2);
        send_baud(24'd3);
        send_baud(24'd3000000);
        send_baud(24'd16000000);
        send_baud(BAUD_ALL_ONES);
        wait_for_results();
    endtask

    task automatic test_zero_reference();
        set_ref_clock('0);
        send_baud(24'd9600);
        send_baud(BAUD_ALL_ONES);
        send_baud('0);
        wait_for_results();
    endtask

    task automatic test_reference_extremes();
        set_ref_clock(32'd1);
        send_baud(24'd1);
        send_baud(BAUD_ALL_ONES);
        wait_for_results();
        set_ref_clock(REF_ALL_ONES);
        send_baud(24'd1);
        send_baud(24'd115200);
        send_baud(24'd16000000);
        send_baud(BAUD_ALL_ONES);
        wait_for_results();
        // back to the usual uart clock after the extremes
        set_ref_clock(32'd50000000);
        send_baud(24'd57600);
        send_baud(24'd921600);
        wait_for_results();
    endtask

    // mostly rates that land inside the divider range for the current clock
    function automatic logic [BAUD_W-1:0] pick_baud();
        longint unsigned k;
        longint unsigned b;
        if ($urandom_range(0, 99) < 30) begin
            if ($urandom_range(0, 1) == 0) return BAUD_W'($urandom);
            return BAUD_W'($urandom_range(1, 16000000));
        end
        if ($urandom_range(0, 1) == 0) k = $urandom_range(10, 3000);
        else k = $urandom_range(3000, 16711425);
        b = longint'(ref_clock_now) / k + $urandom_range(0, 2);
        if (b == 0) b = 1;
        if (b > BAUD_ALL_ONES) b = BAUD_ALL_ONES;
        return BAUD_W'(b);
    endfunction

    task automatic test_random_rates();
        logic [REF_W-1:0] hz;
        int unsigned      phase;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    hz = $urandom_range(1000000, 200000000);
                end
                1: begin
                    hz = $urandom;
                end
                2: begin
                    hz = $urandom_range(1000, 1000000);
                end
                default: begin
                    hz = $urandom_range(0, 1) ? REF_ALL_ONES : REF_CLOCK_RESET;
                end
            endcase
            set_ref_clock(hz);
            quiet = (phase == 2);
            repeat (25) send_baud(pick_baud());
            wait_for_results();
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_clock();
        test_zero_reference();
        test_reference_extremes();
        test_random_rates();
        wait_for_results();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
